@@ rtl/mlpq_pkg.sv @@
// Shared constants, codes and types of the multi-level priority queue.
`default_nettype none
package mlpq_pkg;

    localparam int NUM_LEVELS   = 16;
    localparam int LEVEL_DEPTH  = 16;
    localparam int HANDLE_WIDTH = 16;

    localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LVL_W       = $clog2(NUM_LEVELS);
    localparam int PTR_W       = $clog2(LEVEL_DEPTH);
    localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
    localparam int TOTAL_W     = 9;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Command handed from the classifier to the store side.
    typedef struct packed {
        logic                    rd;
        logic                    wr;
        logic [ADDR_W-1:0]       addr;
        logic [HANDLE_WIDTH-1:0] wdata;
        t_status                 status;
        logic [TOTAL_W-1:0]      total;
        logic                    all_empty;
    } t_cmd;

endpackage
`default_nettype wire

@@ rtl/mlpq_if.sv @@
// Valid/ready channel interfaces for queue requests and results.
`default_nettype none
interface mlpq_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  level;
    logic [15:0] handle;

    modport source (output valid, action, level, handle, input ready);
    modport sink   (input valid, action, level, handle, output ready);
endinterface

interface mlpq_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_handle;
    logic [1:0]  status;
    logic [8:0]  total_held;
    logic        all_empty;

    modport source (output valid, out_handle, status, total_held, all_empty, input ready);
    modport sink   (input valid, out_handle, status, total_held, all_empty, output ready);
endinterface
`default_nettype wire

@@ rtl/multi_level_priority_queue_core.sv @@
// Top level of the strict-priority multi-level queue of task handles.
// Each request (enqueue at a level, or dequeue from the lowest-numbered non-empty
// level) gives exactly one result. The input side holds one request in a register and
// takes no new one until it is classified against the per-level counts and pointers
// and pushed into the command queue, which is when those are updated. A two-entry
// command queue then feeds the handle store, a RAM with registered read: a popped
// command and its read data pass a stage register, then an output register where results
// wait while new requests keep arriving. The store is never cleared: the queue discipline
// reads only slots that were written, so the block is ready straight out of reset.
`default_nettype none
module multi_level_priority_queue_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mlpq_in_if.sink    i_in,
    mlpq_out_if.source o_out
);
    import mlpq_pkg::*;

    logic q_push;
    logic q_ready;
    logic q_valid;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd back_cmd;

    mlpq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_action   (i_in.action),
        .i_level    (i_in.level),
        .i_handle   (i_in.handle),
        .o_q_push   (q_push),
        .i_q_ready  (q_ready),
        .o_q_cmd    (front_cmd)
    );

    mlpq_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_ready (q_ready),
        .i_cmd   (front_cmd),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (back_cmd)
    );

    mlpq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_q_cmd      (back_cmd),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_handle (o_out.out_handle),
        .o_status     (o_out.status),
        .o_total_held (o_out.total_held),
        .o_all_empty  (o_out.all_empty)
    );

endmodule
`default_nettype wire

@@ rtl/mlpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mlpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/mlpq_front.sv @@
// Front end: takes requests, keeps per-level bookkeeping, issues store commands.
`default_nettype none
module mlpq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_action,
    input  logic [7:0]    i_level,
    input  logic [15:0]   i_handle,
    output logic          o_q_push,
    input  logic          i_q_ready,
    output mlpq_pkg::t_cmd o_q_cmd
);
    import mlpq_pkg::*;

    logic                 r_hv;
    logic                 r_act;
    logic [7:0]           r_lvl;
    logic [15:0]          r_hdl;

    logic [CNT_W-1:0]     r_cnt  [NUM_LEVELS];
    logic [PTR_W-1:0]     r_head [NUM_LEVELS];
    logic [PTR_W-1:0]     r_tail [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] r_nonempty;
    logic [TOTAL_W-1:0]   r_total;

    logic [LVL_W-1:0]     first_idx;
    logic                 found;
    logic                 in_range;
    logic [LVL_W-1:0]     idx;
    logic [CNT_W-1:0]     cnt_sel;
    logic [PTR_W-1:0]     head_sel;
    logic [PTR_W-1:0]     tail_sel;
    logic [PTR_W-1:0]     ptr;
    logic                 do_enq;
    logic                 do_deq;
    logic [CNT_W-1:0]     n_cnt_sel;
    logic [NUM_LEVELS-1:0] n_nonempty;
    logic [TOTAL_W-1:0]   n_total;
    logic                 fire;
    t_cmd                 cmd;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Lowest-numbered non-empty level wins.
    always_comb begin
        first_idx = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_nonempty[i]) begin
                first_idx = LVL_W'(i);
            end
        end
    end

    always_comb begin
        found    = |r_nonempty;
        in_range = (r_lvl < 8'(NUM_LEVELS));
        idx      = (r_act == ACT_DEQ) ? first_idx : r_lvl[LVL_W-1:0];
        cnt_sel  = r_cnt[idx];
        head_sel = r_head[idx];
        tail_sel = r_tail[idx];
        do_enq   = 1'b0;
        do_deq   = 1'b0;
        cmd      = '0;
        cmd.status = ST_OK;

        if (r_act == ACT_ENQ) begin
            if (!in_range) begin
                cmd.status = ST_RANGE;
            end else if (cnt_sel == CNT_W'(LEVEL_DEPTH)) begin
                cmd.status = ST_FULL;
            end else begin
                do_enq = 1'b1;
            end
        end else begin
            if (!found) begin
                cmd.status = ST_EMPTY;
            end else begin
                do_deq = 1'b1;
            end
        end

        ptr = do_enq ? tail_sel : head_sel;

        if (do_enq) begin
            n_cnt_sel = cnt_sel + 1'b1;
            n_total   = r_total + 1'b1;
        end else if (do_deq) begin
            n_cnt_sel = cnt_sel - 1'b1;
            n_total   = r_total - 1'b1;
        end else begin
            n_cnt_sel = cnt_sel;
            n_total   = r_total;
        end

        n_nonempty      = r_nonempty;
        n_nonempty[idx] = (n_cnt_sel != '0);

        cmd.rd        = do_deq;
        cmd.wr        = do_enq;
        cmd.addr      = ADDR_W'(idx) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(ptr);
        cmd.wdata     = HANDLE_WIDTH'(r_hdl);
        cmd.total     = n_total;
        cmd.all_empty = ~|n_nonempty;
    end

    assign fire       = r_hv && i_q_ready;
    assign o_in_ready = !r_hv;
    assign o_q_push   = r_hv;
    assign o_q_cmd    = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv       <= 1'b0;
            r_nonempty <= '0;
            r_total    <= '0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_cnt[i]  <= '0;
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
        end else begin
            if (fire) begin
                r_hv <= 1'b0;
            end else if (i_in_valid && !r_hv) begin
                r_hv <= 1'b1;
            end
            if (fire && do_enq) begin
                r_tail[idx] <= next_slot(tail_sel);
            end
            if (fire && do_deq) begin
                r_head[idx] <= next_slot(head_sel);
            end
            if (fire && (do_enq || do_deq)) begin
                r_cnt[idx] <= n_cnt_sel;
                r_nonempty <= n_nonempty;
                r_total    <= n_total;
            end
        end
    end

    // Request holding register.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !r_hv) begin
            r_act <= i_action;
            r_lvl <= i_level;
            r_hdl <= i_handle;
        end
    end

`ifndef SYNTHESIS
    a_nonempty_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nonempty[0] == (r_cnt[0] != '0))
        else $error("nonempty flag of level 0 disagrees with its count");

    a_enq_adds_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && do_enq |=> r_total == TOTAL_W'($past(r_total) + 1'b1))
        else $error("accepted enqueue did not raise the total");

    a_drop_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !do_enq && !do_deq |=> $stable(r_total) && $stable(r_nonempty))
        else $error("dropped request changed the bookkeeping");
`endif

endmodule
`default_nettype wire

@@ rtl/mlpq_cmdq.sv @@
// Two-entry command queue between the front end and the store side.
`default_nettype none
module mlpq_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  mlpq_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_pop,
    output mlpq_pkg::t_cmd o_cmd
);
    import mlpq_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

@@ rtl/mlpq_back.sv @@
// Back end: runs store writes and reads in order and registers the results.
`default_nettype none
module mlpq_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  mlpq_pkg::t_cmd i_q_cmd,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [15:0]    o_out_handle,
    output logic [1:0]     o_status,
    output logic [8:0]     o_total_held,
    output logic           o_all_empty
);
    import mlpq_pkg::*;

    logic                    r_a_valid;
    t_cmd                    r_a_cmd;
    logic                    r_b_valid;
    logic [15:0]             r_b_handle;
    logic [1:0]              r_b_status;
    logic [8:0]              r_b_total;
    logic                    r_b_all_empty;
    logic [HANDLE_WIDTH-1:0] rdata;
    logic                    a_move;
    logic                    pop;

    assign a_move  = r_a_valid && (!r_b_valid || i_out_ready);
    assign pop     = i_q_valid && (!r_a_valid || a_move);
    assign o_q_pop = pop;

    // At most one command per cycle, so a read always sees the write issued before it.
    mlpq_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (pop && i_q_cmd.wr),
        .i_waddr (i_q_cmd.addr),
        .i_wdata (i_q_cmd.wdata),
        .i_re    (pop && i_q_cmd.rd),
        .i_raddr (i_q_cmd.addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            r_b_valid <= a_move || (r_b_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_a_cmd <= i_q_cmd;
        end
        if (a_move) begin
            r_b_handle    <= r_a_cmd.rd ? 16'(rdata) : 16'd0;
            r_b_status    <= r_a_cmd.status;
            r_b_total     <= 9'(r_a_cmd.total);
            r_b_all_empty <= r_a_cmd.all_empty;
        end
    end

    assign o_out_valid  = r_b_valid;
    assign o_out_handle = r_b_handle;
    assign o_status     = r_b_status;
    assign o_total_held = r_b_total;
    assign o_all_empty  = r_b_all_empty;

endmodule
`default_nettype wire
